// File: src/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// shared types, register codes and the gray level helper for the edge
// density detector
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int unsigned ColourW   = 8;
  localparam int unsigned GrayW     = 8;
  localparam int unsigned SumW      = 10;
  localparam int unsigned ScoreW    = 20;
  localparam int unsigned EdgeThrW  = 8;
  localparam int unsigned DensThrW  = 20;
  localparam int unsigned DimW      = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned PixDataW  = 24;
  localparam int unsigned ResDataW  = 24;

  // reciprocal of three, exact for sums below 2^16
  localparam int unsigned RecipW     = 16;
  localparam int unsigned RecipShift = 17;
  localparam logic [RecipW-1:0] Recip3 = 16'hAAAB;

  localparam logic [EdgeThrW-1:0] EdgeThrRst = 8'd70;
  localparam logic [DensThrW-1:0] DensThrRst = 20'd3000;
  localparam logic [DimW-1:0]     FrameWRst  = 11'd320;
  localparam logic [DimW-1:0]     FrameHRst  = 11'd240;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EDGE_THR = 2'd0,
    REG_DENS_THR = 2'd1,
    REG_FRAME_W  = 2'd2,
    REG_FRAME_H  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [EdgeThrW-1:0] edge_thr;
    logic [DensThrW-1:0] dens_thr;
    logic [DimW-1:0]     frame_w;
    logic [DimW-1:0]     frame_h;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [ScoreW-1:0] edge_count;
    logic              maybe_barcode;
  } result_t;

  // floor((r+g+b)/3) by multiplication with the reciprocal
  function automatic logic [GrayW-1:0] gray_of(input logic [SumW-1:0] sum);
    logic [SumW+RecipW-1:0] prod;
    prod    = {{RecipW{1'b0}}, sum} * {{SumW{1'b0}}, Recip3};
    gray_of = prod[RecipShift +: GrayW];
  endfunction

endpackage

// File: src/efd_cfg_regs.sv
// ----------------------------------------------------------------------------
// efd_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module efd_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  efd_pkg::cfg_reg_e       cfg_idx_i,
  input  logic [efd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output efd_pkg::cfg_t           cfg_o
);
  import efd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EDGE_THR: cfg_d.edge_thr = cfg_wdata_i[EdgeThrW-1:0];
        REG_DENS_THR: cfg_d.dens_thr = cfg_wdata_i[DensThrW-1:0];
        REG_FRAME_W:  cfg_d.frame_w  = cfg_wdata_i[DimW-1:0];
        REG_FRAME_H:  cfg_d.frame_h  = cfg_wdata_i[DimW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{edge_thr: EdgeThrRst, dens_thr: DensThrRst,
                 frame_w: FrameWRst, frame_h: FrameHRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/efd_core.sv
// ----------------------------------------------------------------------------
// efd_core
// pixel input register, gray level, edge test and raster position counters
// ----------------------------------------------------------------------------
module efd_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  efd_pkg::cfg_t                 cfg_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  logic [efd_pkg::PixDataW-1:0]  pix_data_i,
  input  logic                          res_ready_i,
  output efd_pkg::result_t              res_o
);
  import efd_pkg::*;

  localparam int unsigned ColW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ColEW = (ColW + 1 > DimW) ? ColW + 1 : DimW;
  localparam int unsigned RowEW = (RowW + 1 > DimW) ? RowW + 1 : DimW;
  localparam logic [ColEW-1:0] MaxW = ColEW'(MAX_WIDTH);
  localparam logic [RowEW-1:0] MaxH = RowEW'(MAX_HEIGHT);

  logic                in_valid_q;
  logic [PixDataW-1:0] pix_q;
  logic [GrayW-1:0]    prev_q, gray;
  logic [ColW-1:0]     col_q;
  logic [RowW-1:0]     row_q;
  logic [ScoreW-1:0]   score_q, score_inc;
  logic [SumW-1:0]     sum;
  logic [GrayW-1:0]    diff;
  logic                hit, row_end, frame_end, advance;
  logic [ColEW-1:0]    w_eff, frame_w_x;
  logic [RowEW-1:0]    h_eff, frame_h_x;

  // effective geometry, clamped to one and to the maximum
  always_comb begin
    frame_w_x = ColEW'(cfg_i.frame_w);
    frame_h_x = RowEW'(cfg_i.frame_h);
    if (frame_w_x == '0)        w_eff = ColEW'(1);
    else if (frame_w_x > MaxW)  w_eff = MaxW;
    else                        w_eff = frame_w_x;
    if (frame_h_x == '0)        h_eff = RowEW'(1);
    else if (frame_h_x > MaxH)  h_eff = MaxH;
    else                        h_eff = frame_h_x;
  end

  always_comb begin
    sum  = SumW'(pix_q[0 +: ColourW]) + SumW'(pix_q[ColourW +: ColourW])
         + SumW'(pix_q[2*ColourW +: ColourW]);
    gray = gray_of(sum);
    diff = (gray > prev_q) ? (gray - prev_q) : (prev_q - gray);
    hit  = (col_q != '0) && (diff >= cfg_i.edge_thr) && (score_q != '1);
    score_inc = score_q + ScoreW'(hit);
    row_end   = (ColEW'(col_q) + ColEW'(1)) >= w_eff;
    frame_end = row_end && ((RowEW'(row_q) + RowEW'(1)) >= h_eff);
    // pixels that give no result never wait for the output side
    advance     = in_valid_q && (!frame_end || res_ready_i);
    pix_ready_o = !in_valid_q || advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      prev_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      score_q    <= '0;
    end else begin
      if (pix_ready_o) begin
        in_valid_q <= pix_valid_i;
      end
      if (advance) begin
        prev_q <= gray;
        if (row_end) begin
          col_q <= '0;
          if (frame_end) begin
            row_q   <= '0;
            score_q <= '0;
          end else begin
            row_q   <= row_q + RowW'(1);
            score_q <= score_inc;
          end
        end else begin
          col_q   <= col_q + ColW'(1);
          score_q <= score_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      pix_q <= pix_data_i;
    end
  end

  assign res_o.valid         = advance && frame_end;
  assign res_o.edge_count    = score_inc;
  assign res_o.maybe_barcode = (score_inc >= cfg_i.dens_thr);

endmodule

// File: src/efd_out_reg.sv
// ----------------------------------------------------------------------------
// efd_out_reg
// result register holding one frame summary until the sink takes it
// ----------------------------------------------------------------------------
module efd_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  efd_pkg::result_t              res_i,
  output logic                          res_ready_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [efd_pkg::ResDataW-1:0]  m_data_o
);
  import efd_pkg::*;

  logic              valid_q;
  logic [ScoreW-1:0] count_q;
  logic              flag_q;

  assign res_ready_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_i.valid) begin
      count_q <= res_i.edge_count;
      flag_q  <= res_i.maybe_barcode;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {{(ResDataW-ScoreW-1){1'b0}}, flag_q, count_q};

endmodule

// File: src/frame_edge_density_detector.sv
// ----------------------------------------------------------------------------
// frame_edge_density_detector
// counts horizontal gray level edges per frame and flags likely barcodes
// ----------------------------------------------------------------------------
// Pixels (one RGB24 transaction each, raster order) enter a one-entry input
// register; the next stage forms gray = floor((r+g+b)/3), compares it with the
// previous pixel of the same row and counts edges, saturating at 2^20-1. On
// the last pixel of a frame one result transaction carries the edge count and
// the maybe_barcode flag, then the count clears. A pixel is taken every cycle
// unless stalled; its result goes out through the result register. The only
// stall comes from the result register: a frame-end pixel waits while an
// earlier result has not yet been taken. Configuration writes are applied at
// once and never reset the raster position or the count.
module frame_edge_density_detector #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  efd_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [efd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // pixel stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [efd_pkg::PixDataW-1:0]  s_axis_tdata_i,  // red[7:0], green[15:8], blue[23:16]
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [efd_pkg::ResDataW-1:0]  m_axis_tdata_o   // edge_count[19:0], maybe_barcode[20]
);
  import efd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_ready;

  // register file
  efd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register, edge test and counters
  efd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pix_valid_i (s_axis_tvalid_i),
    .pix_ready_o (s_axis_tready_o),
    .pix_data_i  (s_axis_tdata_i),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result register towards the sink
  efd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_ready_o (res_ready),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frame edge density detector
// ----------------------------------------------------------------------------
// Drives RGB24 pixel transactions into the detector and checks every frame
// result (edge count and maybe_barcode flag) against a behavioural model of the
// raster walk in the bench or a result typed by hand. A short hand-written table
// comes first: thresholds at both ends, row boundaries, clamped zero sizes and a
// geometry change in the middle of a frame. A random part follows with changing
// settings, two very large geometries and random stalls on both streams.
module tb;
  import efd_pkg::*;

  localparam int unsigned MaxW         = 1024;
  localparam int unsigned MaxH         = 1024;
  localparam int unsigned RandomPixels = 800;
  localparam int unsigned CalmTail     = 100;  // last stretch runs with no random stall bursts
  localparam int unsigned SettleCycles = 6;    // pipeline is two deep, leave margin
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [ScoreW-1:0] ScoreMax = '1;

  typedef enum logic {
    ROW_WRITE,
    ROW_PIXEL
  } row_kind_e;

  // one row of the directed table: either a register write or a pixel, and
  // for a frame-ending pixel optionally the result written out by hand
  typedef struct packed {
    row_kind_e           kind;
    cfg_reg_e            reg_idx;
    logic [CfgDataW-1:0] value;
    logic [ColourW-1:0]  red;
    logic [ColourW-1:0]  green;
    logic [ColourW-1:0]  blue;
    logic                typed;
    logic [ScoreW-1:0]   count;
    logic                flag;
  } stim_row_t;

  typedef struct packed {
    logic [ScoreW-1:0] count;
    logic              flag;
  } frame_result_t;

  localparam stim_row_t DirectedRows [37] = '{
    // reset edge threshold of 70, a 3x2 frame; the step across the row end
    // would count but must not
    '{ROW_WRITE, REG_FRAME_W,  20'd3, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_H,  20'd2, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_DENS_THR, 20'd2, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd255, 8'd0,   8'd0,   1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0,   8'd255, 8'd0,   1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0,   8'd0,   8'd255, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0,   8'd0,   8'd0,   1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd210, 8'd0,   8'd0,   1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd1,   8'd0,   8'd0,   1'b1, 20'd2, 1'b1},
    // zero thresholds: equal neighbours count and any count flags
    '{ROW_WRITE, REG_EDGE_THR, 20'd0, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_DENS_THR, 20'd0, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_W,  20'd2, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_H,  20'd1, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0, 8'd0, 8'd0, 1'b1, 20'd1, 1'b1},
    // full-scale thresholds: only black against white is an edge
    '{ROW_WRITE, REG_EDGE_THR, 20'd255,     8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_DENS_THR, 20'hFFFFF,   8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0,   8'd0,   8'd0,   1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd255, 8'd255, 8'd255, 1'b1, 20'd1, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd255, 8'd255, 8'd255, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd255, 8'd255, 8'd254, 1'b1, 20'd0, 1'b0},
    // geometry shrinks part way through a frame: counters at or past the
    // new limits end the row and the frame on the next pixel
    '{ROW_WRITE, REG_EDGE_THR, 20'd40, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_W,  20'd4,  8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_H,  20'd3,  8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd10,  8'd20,  8'd30,  1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd200, 8'd100, 8'd50,  1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd90,  8'd90,  8'd90,  1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0,   8'd0,   8'd0,   1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd17,  8'd250, 8'd3,   1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_W,  20'd2, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_H,  20'd1, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd130, 8'd130, 8'd130, 1'b0, 20'd0, 1'b0},
    // zero sizes act as one: every pixel is a frame of its own, no edges
    '{ROW_WRITE, REG_FRAME_W,  20'd0, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_FRAME_H,  20'd0, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_WRITE, REG_DENS_THR, 20'd0, 8'd0, 8'd0, 8'd0, 1'b0, 20'd0, 1'b0},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd255, 8'd255, 8'd255, 1'b1, 20'd0, 1'b1},
    '{ROW_PIXEL, REG_EDGE_THR, 20'd0, 8'd0,   8'd0,   8'd0,   1'b1, 20'd0, 1'b1}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic                cfg_we    = 1'b0;
  cfg_reg_e            cfg_idx   = REG_EDGE_THR;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_valid   = 1'b0;
  logic [PixDataW-1:0] s_data    = '0;
  logic                m_ready   = 1'b1;

  // block outputs
  logic                s_ready;
  logic                m_valid;
  logic [ResDataW-1:0] m_data;

  // model copy of the registers and of the raster position
  logic [EdgeThrW-1:0] edge_thr_q = EdgeThrRst;
  logic [DensThrW-1:0] dens_thr_q = DensThrRst;
  logic [DimW-1:0]     frame_w_q  = FrameWRst;
  logic [DimW-1:0]     frame_h_q  = FrameHRst;
  int unsigned         prev_gray  = 0;
  int unsigned         col_pos    = 0;
  int unsigned         row_pos    = 0;
  logic [ScoreW-1:0]   edge_score = '0;

  frame_result_t frame_results_due [$];

  // bookkeeping
  int unsigned mismatches     = 0;
  int unsigned frames_checked = 0;
  int unsigned pixels_sent    = 0;
  int unsigned writes_done    = 0;
  int unsigned drains         = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned stall_left     = 0;
  bit          calm_phase     = 1'b0;

  frame_edge_density_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // result side back-pressure: random stall bursts, none when calm
  always @(negedge clk_i) begin
    if (calm_phase) begin
      m_ready    <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_ready    <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // result check and watchdog, both sampled at the rising edge
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    frame_result_t got;
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d frame results pending",
                 quiet_cycles, frame_results_due.size());
        $display("frame_edge_density_detector test failed");
        $finish;
      end
      if (m_valid && m_ready) begin
        got.count = m_data[ScoreW-1:0];
        got.flag  = m_data[ScoreW];
        if (frame_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: unexpected frame result, count %0d flag %0b",
                     $realtime, got.count, got.flag);
          end
        end else begin
          want = frame_results_due.pop_front();
          frames_checked++;
          if (got.count != want.count || got.flag != want.flag) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: frame %0d expected count %0d flag %0b, got count %0d flag %0b",
                       $realtime, frames_checked, want.count, want.flag, got.count, got.flag);
            end
          end
        end
      end
    end
  end

  // hold the pixel stream low, wait for every pending frame result, then give
  // the pipeline time to swallow pixels that end no frame
  task automatic drain_results(input int unsigned extra);
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_EDGE_THR: edge_thr_q = data[EdgeThrW-1:0];
      REG_DENS_THR: dens_thr_q = data[DensThrW-1:0];
      REG_FRAME_W:  frame_w_q  = data[DimW-1:0];
      REG_FRAME_H:  frame_h_q  = data[DimW-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // send one pixel transaction and walk the raster model over it; a typed
  // result replaces the modelled one on hand-checked rows
  task automatic feed_pixel(input logic [ColourW-1:0] red, green, blue,
                            input logic typed, input logic [ScoreW-1:0] typed_count,
                            input logic typed_flag);
    int unsigned   gray;
    int unsigned   diff;
    int unsigned   w_eff;
    int unsigned   h_eff;
    bit            frame_done;
    frame_result_t res;
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {blue, green, red};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    pixels_sent++;

    gray  = (32'(red) + 32'(green) + 32'(blue)) / 3;
    // sizes of zero act as one, sizes above the maximum act as the maximum
    w_eff = (frame_w_q == '0) ? 1 : ((frame_w_q > MaxW) ? MaxW : frame_w_q);
    h_eff = (frame_h_q == '0) ? 1 : ((frame_h_q > MaxH) ? MaxH : frame_h_q);

    // only pixels after the first of a row are compared
    if (col_pos != 0) begin
      diff = (gray > prev_gray) ? gray - prev_gray : prev_gray - gray;
      if (diff >= edge_thr_q && edge_score != ScoreMax) edge_score++;
    end
    prev_gray  = gray;
    frame_done = 1'b0;
    res        = '0;
    if (col_pos + 1 >= w_eff) begin
      col_pos = 0;
      if (row_pos + 1 >= h_eff) begin
        frame_done = 1'b1;
        res.count  = edge_score;
        res.flag   = (edge_score >= dens_thr_q);
        row_pos    = 0;
        edge_score = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end

    if (typed) begin
      res.count = typed_count;
      res.flag  = typed_flag;
      frame_results_due.push_back(res);
    end else if (frame_done) begin
      frame_results_due.push_back(res);
    end
  endtask

  initial begin : stimulus
    int unsigned         random_pixels;
    int unsigned         phase;
    int unsigned         phase_len;
    int unsigned         value;
    int unsigned         mode;
    bit                  wide_phase;
    bit                  tall_phase;
    logic [CfgDataW-1:0] junk;
    logic [ColourW-1:0]  colour [3];

    random_pixels = 0;
    phase         = 0;
    colour        = '{8'd0, 8'd0, 8'd0};

    // reset held low, then released at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (DirectedRows[k]) begin
      if (DirectedRows[k].kind == ROW_WRITE) begin
        drain_results(SettleCycles);
        write_reg(DirectedRows[k].reg_idx, DirectedRows[k].value);
      end else begin
        feed_pixel(DirectedRows[k].red, DirectedRows[k].green, DirectedRows[k].blue,
                   DirectedRows[k].typed, DirectedRows[k].count, DirectedRows[k].flag);
      end
    end

    // random phases: settings change only once the block has gone quiet,
    // often in the middle of a frame
    while (random_pixels < RandomPixels) begin
      phase++;
      drain_results(SettleCycles);
      wide_phase = (phase == 3);
      tall_phase = (phase == 7);
      if (wide_phase || tall_phase) begin
        // oversized geometry: rows clamp to 1024 pixels, frames to 1024 rows
        write_reg(REG_EDGE_THR, 20'($urandom_range(0, 120)));
        write_reg(REG_DENS_THR, 20'($urandom_range(0, 1100)));
        write_reg(REG_FRAME_W, wide_phase ? 20'd2047 : 20'd0);
        write_reg(REG_FRAME_H, wide_phase ? 20'd1 : 20'd2047);
        phase_len = wide_phase ? 1100 : 1030;
      end else begin
        // unused upper bits of the write data carry noise now and then
        if (phase == 1 || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       value = 0;
            1:       value = 255;
            default: value = $urandom_range(0, 120);
          endcase
          junk = $urandom_range(0, 1) ? 20'($urandom) : '0;
          write_reg(REG_EDGE_THR, {junk[CfgDataW-1:EdgeThrW], 8'(value)});
        end
        if (phase == 1 || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       value = 0;
            1:       value = 32'hFFFFF;
            2:       value = $urandom;
            default: value = $urandom_range(0, 12);
          endcase
          write_reg(REG_DENS_THR, 20'(value));
        end
        if (phase == 1 || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       value = 0;
            1:       value = 1;
            2:       value = $urandom_range(7, 40);
            default: value = $urandom_range(2, 6);
          endcase
          junk = $urandom_range(0, 1) ? 20'($urandom) : '0;
          write_reg(REG_FRAME_W, {junk[CfgDataW-1:DimW], 11'(value)});
        end
        if (phase == 1 || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       value = 0;
            1, 2:    value = $urandom_range(4, 6);
            default: value = $urandom_range(1, 3);
          endcase
          junk = $urandom_range(0, 1) ? 20'($urandom) : '0;
          write_reg(REG_FRAME_H, {junk[CfgDataW-1:DimW], 11'(value)});
        end
        phase_len = $urandom_range(15, 70);
      end

      calm_phase = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        if (random_pixels >= RandomPixels - CalmTail) calm_phase = 1'b1;
        if (!calm_phase && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 11));
        // now and then the sender waits for every pending result
        if (!wide_phase && !tall_phase && $urandom_range(0, 39) == 0) begin
          drain_results(0);
          drains++;
        end
        // mostly random colours, some near the last pixel, some at the rails
        mode = $urandom_range(0, 19);
        for (int c = 0; c < 3; c++) begin
          if (mode < 11) begin
            colour[c] = 8'($urandom);
          end else if (mode < 16) begin
            colour[c] = colour[c] ^ 8'($urandom_range(0, 7));
          end else begin
            colour[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end
        end
        feed_pixel(colour[0], colour[1], colour[2], 1'b0, '0, 1'b0);
        if (!wide_phase && !tall_phase) random_pixels++;
      end
    end

    // wind down: every result in, then a settling wait for stray ones
    drain_results(SettleCycles + 4);

    $display("covered %0d pixels over %0d random phases, %0d register writes, %0d frames checked",
             pixels_sent, phase, writes_done, frames_checked);
    $display("sizes ran from clamped zero to 1024-pixel rows and 1024-row frames, %0d full drains",
             drains);
    if (mismatches == 0) begin
      $display("frame_edge_density_detector test passed");
    end else begin
      $display("frame_edge_density_detector test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/efd_pkg.sv
src/efd_cfg_regs.sv
src/efd_core.sv
src/efd_out_reg.sv
src/frame_edge_density_detector.sv
bench/tb.sv
